// ===== hw/rtl/ckc_pkg.sv =====
`default_nettype none

package ckc_pkg;

    // Fixed field widths of the transaction ports
    localparam int MODE_W    = 2;
    localparam int KEY_W     = 32;
    localparam int FMT_W     = 8;
    localparam int ENTRY_W   = 64;
    localparam int SLOT_W    = 4;

    // Default sizing of the cache
    localparam int DEF_ENTRIES      = 16;
    localparam int DEF_PAYLOAD_BITS = 64;

    // Operation codes carried on the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_STORE  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ckc_tag_array.sv =====
`default_nettype none

// Key and format tags in flops, compared against the lookup key in parallel.
// Only slots below the fill count take part; the lowest matching slot wins.
module ckc_tag_array
    import ckc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int IDX_W   = 4,
    parameter int CNT_W   = 5
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire logic [KEY_W-1:0] wr_key,
    input  wire logic [FMT_W-1:0] wr_fmt,
    input  wire logic [KEY_W-1:0] lk_key,
    input  wire logic [FMT_W-1:0] lk_fmt,
    input  wire logic [CNT_W-1:0] fill_count,
    output logic                  lk_hit,
    output logic      [IDX_W-1:0] lk_idx
);

    logic [KEY_W-1:0] key_reg [ENTRIES];
    logic [FMT_W-1:0] fmt_reg [ENTRIES];
    logic [ENTRIES-1:0] match;

    // Tag write, no reset: entries are only read once written
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_reg[wr_idx] <= wr_key;
            fmt_reg[wr_idx] <= wr_fmt;
        end
    end

    // Per-slot compare, gated by the filled range
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (CNT_W'(i) < fill_count) &&
                       (key_reg[i] == lk_key) && (fmt_reg[i] == lk_fmt);
        end
    end

    // Priority encode, lowest slot first
    always_comb begin
        lk_hit = 1'b0;
        lk_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                lk_hit = 1'b1;
                lk_idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ckc_payload_ram.sv =====
`default_nettype none

// Payload store: one write port, one read port with registered read data
module ckc_payload_ram
    import ckc_pkg::*;
#(
    parameter int ENTRIES      = DEF_ENTRIES,
    parameter int IDX_W        = 4,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    wr_en,
    input  wire logic [IDX_W-1:0]        wr_addr,
    input  wire logic [PAYLOAD_BITS-1:0] wr_data,
    input  wire logic                    rd_en,
    input  wire logic [IDX_W-1:0]        rd_addr,
    output logic      [PAYLOAD_BITS-1:0] rd_data
);

    logic [PAYLOAD_BITS-1:0] mem [ENTRIES];
    logic [PAYLOAD_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while the result stage is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/color_key_cache_round_robin_top.sv =====
`default_nettype none

// Channel   Ports                                             Direction
// input     s_valid s_ready s_mode s_color_key                 in
//           s_format_code s_entry_in
// result    m_valid m_ready m_hit m_entry_out m_slot_used      out
//
// Two register stages: an input register, then the result register.
// One transaction is taken every cycle while m_ready does not stall the
// result stage, the compare and priority encode of all slots plus
// the fill count and pointer update sitting between the two stages.
// aresetn (synchronous, active low) empties both stages and clears the
// fill count and replacement pointer; stored entries are left as they are.
// A stall on m_ready holds the result and backs up into s_ready.
module color_key_cache_round_robin_top
    import ckc_pkg::*;
#(
    parameter int ENTRIES      = DEF_ENTRIES,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [MODE_W-1:0]  s_mode,
    input  wire logic [KEY_W-1:0]   s_color_key,
    input  wire logic [FMT_W-1:0]   s_format_code,
    input  wire logic [ENTRY_W-1:0] s_entry_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_hit,
    output logic      [ENTRY_W-1:0] m_entry_out,
    output logic      [SLOT_W-1:0]  m_slot_used
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

    // Input stage
    logic                    in_valid_reg;
    mode_t                   in_mode_reg;
    logic [KEY_W-1:0]        in_key_reg;
    logic [FMT_W-1:0]        in_fmt_reg;
    logic [PAYLOAD_BITS-1:0] in_payload_reg;

    // Cache control state
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;

    // Result stage
    logic             out_valid_reg;
    logic             out_hit_reg, out_hit_next;
    logic [IDX_W-1:0] out_slot_reg, out_slot_next;

    logic                    advance;
    logic                    take_in;
    logic                    do_store;
    logic                    lk_hit;
    logic [IDX_W-1:0]        lk_idx;
    logic [IDX_W-1:0]        store_idx;
    logic [PAYLOAD_BITS-1:0] rd_data;
    logic [EXT_W-1:0]        slot_ext;

    assign advance  = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || advance;
    assign take_in  = s_valid && s_ready;
    assign do_store = in_valid_reg && advance && (in_mode_reg == MODE_STORE);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_in) begin
            in_mode_reg    <= mode_t'(s_mode);
            in_key_reg     <= s_color_key;
            in_fmt_reg     <= s_format_code;
            in_payload_reg <= s_entry_in[PAYLOAD_BITS-1:0];
        end
    end

    // Slot choice for a store: next free slot, else round robin
    always_comb begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (fill_reg < CNT_W'(ENTRIES)) begin
            store_idx = IDX_W'(fill_reg);
        end else begin
            store_idx = ptr_reg;
        end
        if (in_valid_reg && advance) begin
            case (in_mode_reg)
                MODE_STORE: begin
                    if (fill_reg < CNT_W'(ENTRIES)) begin
                        fill_next = fill_reg + CNT_W'(1);
                    end else if (ptr_reg == IDX_W'(ENTRIES - 1)) begin
                        ptr_next = '0;
                    end else begin
                        ptr_next = ptr_reg + IDX_W'(1);
                    end
                end
                MODE_CLEAR: begin
                    fill_next = '0;
                    ptr_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ptr_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
        end
    end

    ckc_tag_array #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_tags (
        .aclk       (aclk),
        .wr_en      (do_store),
        .wr_idx     (store_idx),
        .wr_key     (in_key_reg),
        .wr_fmt     (in_fmt_reg),
        .lk_key     (in_key_reg),
        .lk_fmt     (in_fmt_reg),
        .fill_count (fill_reg),
        .lk_hit     (lk_hit),
        .lk_idx     (lk_idx)
    );

    ckc_payload_ram #(
        .ENTRIES      (ENTRIES),
        .IDX_W        (IDX_W),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_payload (
        .aclk    (aclk),
        .wr_en   (do_store),
        .wr_addr (store_idx),
        .wr_data (in_payload_reg),
        .rd_en   (advance),
        .rd_addr (lk_idx),
        .rd_data (rd_data)
    );

    // Result fields for the transaction in the input stage
    always_comb begin
        out_hit_next  = 1'b0;
        out_slot_next = '0;
        case (in_mode_reg)
            MODE_LOOKUP: begin
                out_hit_next  = lk_hit;
                out_slot_next = lk_hit ? lk_idx : '0;
            end
            MODE_STORE: begin
                out_slot_next = store_idx;
            end
            default: begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_hit_reg  <= out_hit_next;
            out_slot_reg <= out_slot_next;
        end
    end

    assign slot_ext    = EXT_W'(out_slot_reg);
    assign m_valid     = out_valid_reg;
    assign m_hit       = out_hit_reg;
    assign m_entry_out = out_hit_reg ? ENTRY_W'(rd_data) : '0;
    assign m_slot_used = slot_ext[SLOT_W-1:0];

endmodule

`default_nettype wire
